/* sv/q248_pkg.sv */
`timescale 1ns / 1ps
package q248_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;

  // divider: magnitude of the dividend shifted up by the fraction bits
  localparam int DIV_NUM_W = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = DIV_NUM_W;

  // exponent offsets for the float conversions
  localparam int F2X_BIAS = 150 - FRAC_BITS;
  localparam int X2F_BIAS = 127 - FRAC_BITS;

  // opcodes
  localparam logic [4:0] OP_ADD        = 5'd0;
  localparam logic [4:0] OP_SUB        = 5'd1;
  localparam logic [4:0] OP_MUL        = 5'd2;
  localparam logic [4:0] OP_DIV        = 5'd3;
  localparam logic [4:0] OP_GT         = 5'd4;
  localparam logic [4:0] OP_LT         = 5'd5;
  localparam logic [4:0] OP_GE         = 5'd6;
  localparam logic [4:0] OP_LE         = 5'd7;
  localparam logic [4:0] OP_EQ         = 5'd8;
  localparam logic [4:0] OP_NE         = 5'd9;
  localparam logic [4:0] OP_MIN        = 5'd10;
  localparam logic [4:0] OP_MAX        = 5'd11;
  localparam logic [4:0] OP_INC        = 5'd12;
  localparam logic [4:0] OP_DEC        = 5'd13;
  localparam logic [4:0] OP_FROM_INT   = 5'd14;
  localparam logic [4:0] OP_FROM_FLOAT = 5'd15;
  localparam logic [4:0] OP_TO_FLOAT   = 5'd16;
  localparam logic [4:0] OP_TO_INT     = 5'd17;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NAN  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  localparam logic [DATA_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] FIX_MIN = 32'h8000_0000;

  // result of the non-divide path plus divide sign and zero flags
  typedef struct packed {
    logic              is_div;
    logic              div_neg;
    logic              div_zero;
    logic [DATA_W-1:0] result;
    logic              cmp;
    logic [1:0]        err;
  } side_t;

endpackage

/* sv/fixed_point_q24_8_alu_top.sv */
`timescale 1ns / 1ps
// Signed Q24.8 fixed-point ALU on stream ports. One beat is accepted every
// cycle while no output beat waits, and every beat gives exactly one result
// beat, in order. The latency is set by the divider, a chain of 40 one-bit
// restoring stages, which every opcode travels alongside. The whole pipe
// holds while the output beat waits on m_axis_tready. Input tuser carries
// the opcode; output tuser carries compare_true and error_code.
module fixed_point_q24_8_alu_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
  input  logic [4:0]  s_axis_tuser,  // kind [4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value [31:0]
  output logic [2:0]  m_axis_tuser   // compare_true [0], error_code [2:1]
);
  import q248_pkg::*;

  localparam int DLY = DIV_STEPS - 2;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: input register
  logic                     v1;
  logic [4:0]               kind1;
  logic signed [DATA_W-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1 <= s_axis_tuser;
      a1    <= s_axis_tdata[31:0];
      b1    <= s_axis_tdata[63:32];
    end
  end

  // magnitudes for divider and float conversion
  logic [DATA_W-1:0] mag_a, mag_b;
  assign mag_a = a1[DATA_W-1] ? (~a1 + 1'b1) : a1;
  assign mag_b = b1[DATA_W-1] ? (~b1 + 1'b1) : b1;

  logic [DIV_NUM_W-1:0] quo;

  q248_div u_div (
    .clk (clk),
    .en  (en),
    .num ({mag_a, {FRAC_BITS{1'b0}}}),
    .den (mag_b),
    .quo (quo)
  );

  // stage 2 logic: ops that complete within this stage
  side_t            simple;
  logic [DATA_W:0]  sum_add, sum_sub;
  logic [FRAC_BITS:0] top_a;

  assign sum_add = {a1[DATA_W-1], a1} + {b1[DATA_W-1], b1};
  assign sum_sub = {a1[DATA_W-1], a1} - {b1[DATA_W-1], b1};
  assign top_a   = a1[DATA_W-1:DATA_W-1-FRAC_BITS];

  always_comb begin
    simple          = '0;
    simple.is_div   = (kind1 == OP_DIV);
    simple.div_neg  = a1[DATA_W-1] ^ b1[DATA_W-1];
    simple.div_zero = (b1 == '0);
    case (kind1)
      OP_ADD: begin
        simple.result = sum_add[DATA_W-1:0];
        simple.err    = (sum_add[DATA_W] != sum_add[DATA_W-1]) ? ERR_OVF : ERR_NONE;
      end
      OP_SUB: begin
        simple.result = sum_sub[DATA_W-1:0];
        simple.err    = (sum_sub[DATA_W] != sum_sub[DATA_W-1]) ? ERR_OVF : ERR_NONE;
      end
      OP_GT:  simple.cmp = (a1 > b1);
      OP_LT:  simple.cmp = (a1 < b1);
      OP_GE:  simple.cmp = (a1 >= b1);
      OP_LE:  simple.cmp = (a1 <= b1);
      OP_EQ:  simple.cmp = (a1 == b1);
      OP_NE:  simple.cmp = (a1 != b1);
      OP_MIN: simple.result = (a1 < b1) ? a1 : b1;
      OP_MAX: simple.result = (a1 > b1) ? a1 : b1;
      OP_INC: begin
        simple.result = a1 + 1'b1;
        simple.err    = (a1 == FIX_MAX) ? ERR_OVF : ERR_NONE;
      end
      OP_DEC: begin
        simple.result = a1 - 1'b1;
        simple.err    = (a1 == FIX_MIN) ? ERR_OVF : ERR_NONE;
      end
      OP_FROM_INT: begin
        simple.result = a1 <<< FRAC_BITS;
        simple.err    = ((&top_a) || !(|top_a)) ? ERR_NONE : ERR_OVF;
      end
      OP_TO_INT: simple.result = a1 >>> FRAC_BITS;
      default: ;
    endcase
  end

  // stage 2 logic: float to fixed, align mantissa
  logic [7:0]  f_exp;
  logic [23:0] f_m24;
  logic [8:0]  f_e;
  logic signed [9:0] f_shift;
  logic [7:0]  f_n;
  logic [55:0] f_mag;
  logic [32:0] f_mag33;
  logic        f_nan, f_inf;

  assign f_exp = a1[30:23];
  assign f_m24 = {(f_exp != 8'd0), a1[22:0]};
  assign f_e   = (f_exp != 8'd0) ? {1'b0, f_exp} : 9'd1;
  assign f_shift = $signed({1'b0, f_e}) - 10'(F2X_BIAS);
  assign f_n     = 8'(-f_shift);
  assign f_nan   = (f_exp == 8'hFF) && (a1[22:0] != '0);
  assign f_inf   = (f_exp == 8'hFF) && (a1[22:0] == '0);

  always_comb begin
    if (f_shift >= 0) begin
      if (f_shift > 10'sd31) begin
        f_mag = 56'h1_0000_0000;
      end else begin
        f_mag = {32'd0, f_m24} << f_shift[4:0];
      end
    end else if (f_n >= 8'd25) begin
      f_mag = '0;
    end else begin
      f_mag = ({32'd0, f_m24} + (56'd1 << (f_n - 8'd1))) >> f_n;
    end
    f_mag33 = (|f_mag[55:32]) ? 33'h1_0000_0000 : {1'b0, f_mag[31:0]};
  end

  // stage 2 logic: fixed to float, find leading one
  logic [4:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (mag_a[i]) lead = 5'(i);
    end
  end

  // stage 2 registers
  logic              v2;
  logic [4:0]        kind2;
  side_t             side2;
  logic signed [63:0] prod2;
  logic [32:0]       f_mag2;
  logic              f_nan2, f_inf2, sgn2;
  logic [DATA_W-1:0] x_mag2;
  logic [4:0]        lead2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2  <= kind1;
      side2  <= simple;
      prod2  <= a1 * b1;
      f_mag2 <= f_mag33;
      f_nan2 <= f_nan;
      f_inf2 <= f_inf;
      sgn2   <= a1[DATA_W-1];
      x_mag2 <= mag_a;
      lead2  <= lead;
    end
  end

  // stage 3 logic: finish multiply and conversions
  side_t              side3_next;
  logic [63-FRAC_BITS-DATA_W+1:0] p_top;
  logic [DATA_W-1:0]  norm;
  logic [24:0]        m25;
  logic               rnd_up;
  logic [7:0]         x_exp;

  assign p_top  = prod2[63:FRAC_BITS+DATA_W-1];
  assign norm   = x_mag2 << (5'd31 - lead2);
  assign rnd_up = norm[7] && ((|norm[6:0]) || norm[8]);
  assign m25    = {1'b0, norm[31:8]} + {24'd0, rnd_up};
  assign x_exp  = 8'(lead2) + 8'(X2F_BIAS) + {7'd0, m25[24]};

  always_comb begin
    side3_next = side2;
    case (kind2)
      OP_MUL: begin
        side3_next.result = prod2[FRAC_BITS+DATA_W-1:FRAC_BITS];
        side3_next.err    = ((&p_top) || !(|p_top)) ? ERR_NONE : ERR_OVF;
      end
      OP_FROM_FLOAT: begin
        if (f_nan2) begin
          side3_next.result = '0;
          side3_next.err    = ERR_NAN;
        end else if (f_inf2) begin
          side3_next.result = sgn2 ? FIX_MIN : FIX_MAX;
          side3_next.err    = ERR_OVF;
        end else if (sgn2) begin
          if (f_mag2 > 33'h0_8000_0000) begin
            side3_next.result = FIX_MIN;
            side3_next.err    = ERR_OVF;
          end else begin
            side3_next.result = ~f_mag2[DATA_W-1:0] + 1'b1;
          end
        end else if (f_mag2 > 33'h0_7FFF_FFFF) begin
          side3_next.result = FIX_MAX;
          side3_next.err    = ERR_OVF;
        end else begin
          side3_next.result = f_mag2[DATA_W-1:0];
        end
      end
      OP_TO_FLOAT: begin
        if (x_mag2 == '0) begin
          side3_next.result = '0;
        end else begin
          side3_next.result = {sgn2, x_exp, m25[22:0]};
        end
      end
      default: ;
    endcase
  end

  // stage 3 and delay line up to the divider output
  side_t      dl [DLY+1];
  logic [DLY:0] vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[DLY-1:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= side3_next;
      for (int i = 1; i <= DLY; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // output stage: merge divider result
  side_t             fin;
  logic [DATA_W-1:0] q_lo;
  logic              q_big;

  assign q_lo  = quo[DATA_W-1:0];
  assign q_big = |quo[DIV_NUM_W-1:DATA_W];

  always_comb begin
    fin = dl[DLY];
    if (dl[DLY].is_div) begin
      fin.cmp = 1'b0;
      if (dl[DLY].div_zero) begin
        fin.result = '0;
        fin.err    = ERR_NAN;
      end else if (dl[DLY].div_neg) begin
        fin.result = ~q_lo + 1'b1;
        fin.err    = (q_big || q_lo > FIX_MIN) ? ERR_OVF : ERR_NONE;
      end else begin
        fin.result = q_lo;
        fin.err    = (q_big || q_lo > FIX_MAX) ? ERR_OVF : ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vd[DLY];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= fin.result;
      m_axis_tuser <= {fin.err, fin.cmp};
    end
  end

  // checks
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
    else $error("error code out of range");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == '0 && m_axis_tuser[2:1] == ERR_NONE))
    else $error("compare beat carries value or error");

  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:1] == ERR_NAN) |-> m_axis_tdata == '0)
    else $error("divide by zero or NaN beat has nonzero value");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

/* sv/q248_div.sv */
`timescale 1ns / 1ps
module q248_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [q248_pkg::DIV_NUM_W-1:0]   num,
  input  logic [q248_pkg::DATA_W-1:0]      den,
  output logic [q248_pkg::DIV_NUM_W-1:0]   quo
);
  import q248_pkg::*;

  // one restoring step: bring in the next numerator bit, subtract if it fits
  typedef struct packed {
    logic [DATA_W-1:0]    rem;
    logic [DIV_NUM_W-1:0] work;
    logic [DATA_W-1:0]    den;
  } step_t;

  function automatic step_t div_step(step_t s);
    step_t            r;
    logic [DATA_W:0]  t;
    logic [DATA_W:0]  d;
    t = {s.rem, s.work[DIV_NUM_W-1]};
    d = t - {1'b0, s.den};
    r.den = s.den;
    if (!d[DATA_W]) begin
      r.rem  = d[DATA_W-1:0];
      r.work = {s.work[DIV_NUM_W-2:0], 1'b1};
    end else begin
      r.rem  = t[DATA_W-1:0];
      r.work = {s.work[DIV_NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  step_t stg [DIV_STEPS];
  step_t head;

  assign head = '{rem: '0, work: num, den: den};

  // advance every step register together
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= div_step(head);
      for (int i = 1; i < DIV_STEPS; i++) begin
        stg[i] <= div_step(stg[i-1]);
      end
    end
  end

  assign quo = stg[DIV_STEPS-1].work;

endmodule

/* tb/fixed_point_q24_8_alu_top_tb.sv */
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_top_tb;
  import q248_pkg::*;

  localparam int N_RANDOM   = 925;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_WAIT = 60;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  err;
  } alu_out_t;

  typedef struct {
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic        has_exp;
    alu_out_t    exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  alu_out_t  pending_results[$];
  alu_out_t  typed_results[$];
  bit        typed_flags[$];
  int        n_fail = 0;
  int        n_checked = 0;
  int        idle_cycles = 0;
  int        out_idle = 0;
  bit        quiet_phase = 1'b0;

  fixed_point_q24_8_alu_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // IEEE single pattern to raw fixed, half away from zero, saturating
  function automatic logic [33:0] float_to_q(logic [31:0] bits);
    logic [1:0]  err;
    logic [7:0]  ex;
    logic [63:0] m;
    logic [63:0] mag;
    int          sh;
    err = ERR_NONE;
    ex  = bits[30:23];
    m   = {41'd0, bits[22:0]};
    if (ex == 8'hFF) begin
      if (m != 0) return {ERR_NAN, 32'd0};
      return {ERR_OVF, bits[31] ? FIX_MIN : FIX_MAX};
    end
    if (ex != 0) m[23] = 1'b1;
    else ex = 8'd1;
    sh = int'(ex) - 150 + FRAC_BITS;
    if (sh >= 0) mag = (sh > 31) ? 64'h8000_0001 : (m << sh);
    else if (-sh >= 25) mag = 0;
    else mag = (m + (64'd1 << (-sh - 1))) >> (-sh);
    if (bits[31]) begin
      if (mag > 64'h8000_0000) return {ERR_OVF, FIX_MIN};
      return {ERR_NONE, 32'(-mag)};
    end
    if (mag > 64'h7FFF_FFFF) return {ERR_OVF, FIX_MAX};
    return {ERR_NONE, mag[31:0]};
  endfunction

  // raw fixed to IEEE single, nearest even
  function automatic logic [31:0] q_to_float(logic [31:0] a);
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  ex;
    int          p;
    int          s;
    mag = a[31] ? -a : a;
    if (mag == 0) return 32'd0;
    p = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = i;
    ex = 8'(p + 127 - FRAC_BITS);
    if (p <= 23) mant = mag << (23 - p);
    else begin
      s    = p - 23;
      rem  = mag & ((32'd1 << s) - 1);
      half = 32'd1 << (s - 1);
      mant = mag >> s;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        ex++;
      end
    end
    return {a[31], ex, mant[22:0]};
  endfunction

  function automatic alu_out_t alu_predict(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    alu_out_t    r;
    logic [63:0] wide;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [33:0] cv;
    bit          wraps;
    r     = '0;
    wraps = 1'b0;
    wide  = '0;
    case (op)
      OP_ADD: begin wide = 64'($signed(a)) + 64'($signed(b)); wraps = 1'b1; end
      OP_SUB: begin wide = 64'($signed(a)) - 64'($signed(b)); wraps = 1'b1; end
      OP_MUL: begin
        wide  = 64'($signed($signed(64'($signed(a))) * $signed(64'($signed(b)))) >>> FRAC_BITS);
        wraps = 1'b1;
      end
      OP_DIV: begin
        if (b == 0) r.err = ERR_NAN;
        else begin
          ma    = a[31] ? -64'($signed(a)) : 64'($signed(a));
          mb    = b[31] ? -64'($signed(b)) : 64'($signed(b));
          q     = (ma << FRAC_BITS) / mb;
          wide  = (a[31] != b[31]) ? -q : q;
          wraps = 1'b1;
        end
      end
      OP_GT: r.cmp = $signed(a) >  $signed(b);
      OP_LT: r.cmp = $signed(a) <  $signed(b);
      OP_GE: r.cmp = $signed(a) >= $signed(b);
      OP_LE: r.cmp = $signed(a) <= $signed(b);
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = ($signed(a) < $signed(b)) ? a : b;
      OP_MAX: r.value = ($signed(a) > $signed(b)) ? a : b;
      OP_INC: begin wide = 64'($signed(a)) + 1; wraps = 1'b1; end
      OP_DEC: begin wide = 64'($signed(a)) - 1; wraps = 1'b1; end
      OP_FROM_INT: begin wide = 64'($signed(a)) <<< FRAC_BITS; wraps = 1'b1; end
      OP_FROM_FLOAT: begin
        cv      = float_to_q(a);
        r.value = cv[31:0];
        r.err   = cv[33:32];
      end
      OP_TO_FLOAT: r.value = q_to_float(a);
      OP_TO_INT: r.value = 32'($signed(a) >>> FRAC_BITS);
      default: ;
    endcase
    if (wraps) begin
      r.value = wide[31:0];
      if (wide != 64'($signed(wide[31:0]))) r.err = ERR_OVF;
    end
    return r;
  endfunction

  // random operand biased toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? FIX_MAX : FIX_MIN + $urandom_range(0, 2);
      1: return 32'($signed($urandom_range(0, 4096)) - 2048);
      2: return 32'($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 4))
      0: f[30:23] = 8'hFF;
      1: f[30:23] = 8'd0;
      2: f[30:23] = 8'($urandom_range(100, 170));
      default: ;
    endcase
    return f;
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_beat(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    pending_results.push_back(alu_predict(op, a, b));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // output side: random stall bursts with tready low
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_idle      <= 0;
    end else if (quiet_phase) begin
      m_axis_tready <= 1'b1;
      out_idle      <= 0;
    end else if (out_idle > 0) begin
      m_axis_tready <= 1'b0;
      out_idle      <= out_idle - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      out_idle      <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction or directed result
  always @(posedge clk) begin
    alu_out_t got;
    alu_out_t want;
    bit       typed;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        n_fail++;
      end else begin
        want  = pending_results.pop_front();
        typed = 1'b0;
        if (typed_flags.size() != 0) begin
          typed = typed_flags.pop_front();
          if (typed) want = typed_results.pop_front();
        end
        n_checked++;
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          n_fail++;
        end
        if (got.cmp !== want.cmp) begin
          $display("%0t: compare expected %b actual %b", $time, want.cmp, got.cmp);
          n_fail++;
        end
        if (got.err !== want.err) begin
          $display("%0t: error code expected %0d actual %0d", $time, want.err, got.err);
          n_fail++;
        end
      end
    end
  end

  // stop when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (s_axis_tvalid || pending_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("%0t: watchdog, no progress", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [4:0] op;
    int         roll;
    int         drain;

    // directed rows; typed results where obvious
    rows.push_back('{OP_ADD, FIX_MAX, 32'd1, 1, '{FIX_MIN, 1'b0, ERR_OVF}});
    rows.push_back('{OP_SUB, FIX_MIN, 32'd1, 1, '{FIX_MAX, 1'b0, ERR_OVF}});
    rows.push_back('{OP_MUL, 32'h0000_0300, 32'hFFFF_FE00, 1, '{32'hFFFF_FA00, 1'b0, ERR_NONE}});
    rows.push_back('{OP_MUL, FIX_MAX, FIX_MAX, 0, '0});
    rows.push_back('{OP_MUL, FIX_MIN, FIX_MIN, 0, '0});
    rows.push_back('{OP_DIV, 32'h0000_0100, 32'd0, 1, '{32'd0, 1'b0, ERR_NAN}});
    rows.push_back('{OP_DIV, FIX_MIN, 32'hFFFF_FFFF, 0, '0});
    rows.push_back('{OP_DIV, 32'hFFFF_F900, 32'h0000_0200, 0, '0});
    rows.push_back('{OP_GT, 32'd5, 32'hFFFF_FFFF, 1, '{32'd0, 1'b1, ERR_NONE}});
    rows.push_back('{OP_LT, FIX_MIN, FIX_MAX, 1, '{32'd0, 1'b1, ERR_NONE}});
    rows.push_back('{OP_GE, 32'd7, 32'd7, 1, '{32'd0, 1'b1, ERR_NONE}});
    rows.push_back('{OP_LE, FIX_MAX, FIX_MIN, 1, '{32'd0, 1'b0, ERR_NONE}});
    rows.push_back('{OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'd0, 1'b1, ERR_NONE}});
    rows.push_back('{OP_NE, 32'd0, 32'd0, 1, '{32'd0, 1'b0, ERR_NONE}});
    rows.push_back('{OP_MIN, FIX_MIN, FIX_MAX, 1, '{FIX_MIN, 1'b0, ERR_NONE}});
    rows.push_back('{OP_MAX, FIX_MIN, FIX_MAX, 1, '{FIX_MAX, 1'b0, ERR_NONE}});
    rows.push_back('{OP_INC, FIX_MAX, 32'd0, 1, '{FIX_MIN, 1'b0, ERR_OVF}});
    rows.push_back('{OP_DEC, FIX_MIN, 32'd0, 1, '{FIX_MAX, 1'b0, ERR_OVF}});
    rows.push_back('{OP_FROM_INT, 32'h0080_0000, 32'd0, 1, '{FIX_MIN, 1'b0, ERR_OVF}});
    rows.push_back('{OP_FROM_FLOAT, 32'h7FC0_0001, 32'd0, 1, '{32'd0, 1'b0, ERR_NAN}});
    rows.push_back('{OP_FROM_FLOAT, 32'hFF80_0000, 32'd0, 1, '{FIX_MIN, 1'b0, ERR_OVF}});
    rows.push_back('{OP_FROM_FLOAT, 32'h3FC0_0000, 32'd0, 1, '{32'h0000_0180, 1'b0, ERR_NONE}});
    rows.push_back('{OP_TO_FLOAT, 32'h0000_0100, 32'd0, 1, '{32'h3F80_0000, 1'b0, ERR_NONE}});
    rows.push_back('{OP_TO_FLOAT, FIX_MAX, 32'd0, 0, '0});
    rows.push_back('{OP_TO_INT, FIX_MIN, 32'd0, 1, '{32'hFF80_0000, 1'b0, ERR_NONE}});
    rows.push_back('{5'd31, FIX_MAX, FIX_MAX, 1, '{32'd0, 1'b0, ERR_NONE}});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (rows[i]) begin
      row = rows[i];
      typed_flags.push_back(row.has_exp);
      if (row.has_exp) typed_results.push_back(row.exp);
      send_beat(row.op, row.a, row.b);
    end

    // random beats; the tail runs without idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 150) quiet_phase = 1'b1;
      roll = $urandom_range(0, 19);
      op   = (roll == 19) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
      typed_flags.push_back(1'b0);
      if (op == OP_FROM_FLOAT) send_beat(op, pick_float(), $urandom);
      else if (op == OP_DIV && $urandom_range(0, 9) == 0) send_beat(op, pick_operand(), 32'd0);
      else send_beat(op, pick_operand(), pick_operand());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then a short settle
    drain = 0;
    while (pending_results.size() != 0 && drain < 20 * STALL_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d result beats over %0d opcodes incl. undefined ones,",
             n_checked, 32);
    $display("  with wrap, divide by zero, NaN and saturation cases, %0d mismatches.", n_fail);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* fixed_point_q24_8_alu_top.f */
sv/q248_pkg.sv
sv/q248_div.sv
sv/fixed_point_q24_8_alu_top.sv
tb/fixed_point_q24_8_alu_top_tb.sv
